[design/wrc_pkg.sv]
package wrc_pkg;

	// one input beat: a file byte and its end-of-file mark
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} wrc_in_t;

	// one result beat
	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  audio_byte;
		logic        data_start;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [31:0] bytes_per_second;
		logic [15:0] bits_per_sample;
		logic        format_seen;
		logic        file_end;
		logic        truncated;
		logic        rejected;
	} wrc_out_t;

	// parser phase
	typedef enum logic [2:0] {
		PH_FILE = 3'd0,
		PH_CHDR = 3'd1,
		PH_PAY  = 3'd2,
		PH_PAD  = 3'd3,
		PH_REJ  = 3'd4
	} wrc_phase_t;

	// byte class codes
	localparam logic [2:0] CLS_FILE_HDR  = 3'd0;
	localparam logic [2:0] CLS_CHUNK_HDR = 3'd1;
	localparam logic [2:0] CLS_FORMAT    = 3'd2;
	localparam logic [2:0] CLS_AUDIO     = 3'd3;
	localparam logic [2:0] CLS_SKIPPED   = 3'd4;
	localparam logic [2:0] CLS_REJECTED  = 3'd5;

	// chunk names, first byte in the high bits
	localparam logic [31:0] NAME_FMT  = 32'h666D_7420;
	localparam logic [31:0] NAME_DATA = 32'h6461_7461;

	// file and chunk header last positions, format end offset
	localparam logic [3:0] HDR_LAST_POS  = 4'd11;
	localparam logic [2:0] CHDR_LAST_POS = 3'd7;
	localparam logic [4:0] FMT_END_OFF   = 5'd16;

	// flag bits
	localparam int FLAG_FMT   = 0;
	localparam int FLAG_REJ   = 1;
	localparam int FLAG_START = 2;

	// full parser state
	typedef struct packed {
		wrc_phase_t  phase;
		logic [3:0]  field_index;
		logic [31:0] chunk_name;
		logic [31:0] bytes_left;
		logic [4:0]  format_offset;
		logic [15:0] channel_reg;
		logic [31:0] rate_reg;
		logic [31:0] byte_rate_reg;
		logic [15:0] width_reg;
		logic [2:0]  flags;
	} wrc_state_t;

	// expected file header byte; size field positions are never compared
	function automatic logic [7:0] magic_byte(input logic [3:0] pos);
		logic [7:0] m;
		unique case (pos)
			4'd0:    m = 8'h52;
			4'd1:    m = 8'h49;
			4'd2:    m = 8'h46;
			4'd3:    m = 8'h46;
			4'd8:    m = 8'h57;
			4'd9:    m = 8'h41;
			4'd10:   m = 8'h56;
			4'd11:   m = 8'h45;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

[design/wrc_parse_core.sv]
module wrc_parse_core
	import wrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step_en,
	input  wrc_in_t  beat,
	output wrc_out_t result
);

	wrc_state_t state_q;
	wrc_state_t nxt;
	wrc_state_t upd;
	logic [2:0]  cls;
	logic [7:0]  audio;
	logic        start;
	logic        trunc;
	logic [3:0]  hdr_pos;
	logic [2:0]  ch_pos;
	logic [31:0] bl_dec;

	// header position, clamped to the last magic byte
	assign hdr_pos = (state_q.field_index > HDR_LAST_POS) ? HDR_LAST_POS : state_q.field_index;
	assign ch_pos  = state_q.field_index[2:0];
	assign bl_dec  = state_q.bytes_left - 32'd1;

	// per-byte parse step
	always_comb begin
		upd   = state_q;
		cls   = CLS_REJECTED;
		audio = 8'h00;
		start = 1'b0;
		trunc = 1'b0;
		case (state_q.phase)
			PH_FILE: begin
				cls = CLS_FILE_HDR;
				if ((hdr_pos < 4'd4 || hdr_pos >= 4'd8) && beat.in_byte != magic_byte(hdr_pos)) begin
					cls                  = CLS_REJECTED;
					upd.flags[FLAG_REJ]  = 1'b1;
					upd.phase            = PH_REJ;
				end else if (hdr_pos == HDR_LAST_POS) begin
					upd.phase       = PH_CHDR;
					upd.field_index = 4'd0;
				end else begin
					upd.field_index = hdr_pos + 4'd1;
				end
			end
			PH_CHDR: begin
				cls = CLS_CHUNK_HDR;
				if (ch_pos < 3'd4) begin
					upd.chunk_name = {state_q.chunk_name[23:0], beat.in_byte};
				end else begin
					upd.bytes_left[{ch_pos[1:0], 3'b000} +: 8] = beat.in_byte;
				end
				if (ch_pos == CHDR_LAST_POS) begin
					upd.format_offset = 5'd0;
					if (state_q.chunk_name == NAME_FMT) begin
						upd.flags[FLAG_FMT] = 1'b1;
					end
					if (state_q.chunk_name == NAME_DATA) begin
						upd.flags[FLAG_START] = 1'b1;
					end
					if (upd.bytes_left != 32'd0) begin
						upd.phase       = PH_PAY;
						upd.field_index = {3'b000, upd.bytes_left[0]};
					end else begin
						upd.field_index = 4'd0;
					end
				end else begin
					upd.field_index = {1'b0, ch_pos + 3'd1};
				end
			end
			PH_PAY: begin
				if (state_q.chunk_name == NAME_FMT) begin
					cls = CLS_FORMAT;
					case (state_q.format_offset) inside
						5'd2, 5'd3: begin
							upd.channel_reg[{state_q.format_offset[0], 3'b000} +: 8] = beat.in_byte;
						end
						[5'd4:5'd7]: begin
							upd.rate_reg[{state_q.format_offset[1:0], 3'b000} +: 8] = beat.in_byte;
						end
						[5'd8:5'd11]: begin
							upd.byte_rate_reg[{state_q.format_offset[1:0], 3'b000} +: 8] =
								beat.in_byte;
						end
						5'd14, 5'd15: begin
							upd.width_reg[{state_q.format_offset[0], 3'b000} +: 8] = beat.in_byte;
						end
						default: begin
						end
					endcase
					if (state_q.format_offset < FMT_END_OFF) begin
						upd.format_offset = state_q.format_offset + 5'd1;
					end
				end else if (state_q.chunk_name == NAME_DATA) begin
					cls                   = CLS_AUDIO;
					audio                 = beat.in_byte;
					start                 = state_q.flags[FLAG_START];
					upd.flags[FLAG_START] = 1'b0;
				end else begin
					cls = CLS_SKIPPED;
				end
				upd.bytes_left = bl_dec;
				if (bl_dec == 32'd0) begin
					upd.phase       = state_q.field_index[0] ? PH_PAD : PH_CHDR;
					upd.field_index = 4'd0;
				end else if (beat.last_byte) begin
					trunc = 1'b1;
				end
			end
			PH_PAD: begin
				cls             = CLS_SKIPPED;
				upd.phase       = PH_CHDR;
				upd.field_index = 4'd0;
			end
			default: begin
				cls = CLS_REJECTED;
			end
		endcase
	end

	// restart after the last byte of a file
	always_comb begin
		nxt = upd;
		if (beat.last_byte) begin
			nxt = '0;
		end
	end

	// result fields, taken after this byte's update
	always_comb begin
		result.byte_class       = cls;
		result.audio_byte       = audio;
		result.data_start       = start;
		result.channels         = upd.channel_reg;
		result.sample_rate      = upd.rate_reg;
		result.bytes_per_second = upd.byte_rate_reg;
		result.bits_per_sample  = upd.width_reg;
		result.format_seen      = upd.flags[FLAG_FMT];
		result.file_end         = beat.last_byte;
		result.truncated        = trunc;
		result.rejected         = upd.flags[FLAG_REJ];
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step_en) begin
			state_q <= nxt;
		end
	end

	// end of file always returns the parser to the file header
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && beat.last_byte |=> state_q.phase == PH_FILE && state_q.field_index == 4'd0
			&& state_q.flags == 3'b000)
		else $error("parser did not restart after file end");

	// a rejected file stays rejected until its end
	a_rej_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.flags[FLAG_REJ] && !(step_en && beat.last_byte) |=> state_q.flags[FLAG_REJ])
		else $error("rejected flag dropped inside a file");

endmodule

[design/wav_riff_chunk_parser.sv]
// channel | dir | handshake           | payload
// --------+-----+---------------------+------------------------------------------
// in      | in  | in_valid / in_ready | in_data  (wrc_in_t: byte, last mark)
// out     | out | out_valid/out_ready | out_data (wrc_out_t: class, audio, format)
//
// one byte per clock sustained while out is not stalled; a result is offered once its
// byte has passed the input register and the result register; the parser state updates
// as a beat moves between the two registers, so the state loop is the timing limit
// async active-low reset clears the parser state and both valid bits
// a stall on out holds the result; in keeps accepting until the input register is full
module wav_riff_chunk_parser
	import wrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  wrc_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output wrc_out_t out_data
);

	logic     valid_s1;
	wrc_in_t  data_s1;
	logic     out_valid_q;
	wrc_out_t out_data_q;
	wrc_out_t result;
	logic     adv;
	logic     step_en;

	// flow control
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign step_en  = valid_s1 && adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// parse step
	wrc_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.beat    (data_s1),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// truncation is only reported on the last beat of a file
	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.truncated |-> out_data.file_end)
		else $error("truncated without file end");

	// audio byte and start mark only on audio beats
	a_audio_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_class != CLS_AUDIO |->
			out_data.audio_byte == 8'h00 && !out_data.data_start)
		else $error("audio fields set on a non-audio beat");

	// rejected beats carry the rejected flag
	a_rej_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_class == CLS_REJECTED |-> out_data.rejected)
		else $error("rejected class without rejected flag");

endmodule
